// ===== rtl/core/rud_pkg.sv =====
// Package for the pipelined unsigned divider.
// Holds the default operand width shared by the top level and the divider stage.
// No dependencies.
package rud_pkg;

    localparam int DATA_WIDTH_DEFAULT = 32;

endpackage

// ===== rtl/core/unsigned_divider_32.sv =====
// Top level of the pipelined unsigned restoring divider.
// Chains one rud_stage per quotient bit; depends on rud_pkg and rud_stage.
//
//   Channel  Handshake              Word contents
//   input    in_valid / in_ready    dividend, divisor
//   output   out_valid / out_ready  quotient, remainder, divide_by_zero
//
// One word enters per cycle while the output is not stalled; each word resolves one quotient bit in each stage.
// Reset clears the valid bit of every stage and takes effect at once.
// A stalled output backs up stage by stage; empty stages keep filling meanwhile.
module unsigned_divider_32 #(
    parameter int DATA_WIDTH = rud_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder,
    output logic                  divide_by_zero
);

    logic                  valid_w [0:DATA_WIDTH];
    logic                  ready_w [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] nq_w    [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] div_w   [0:DATA_WIDTH];
    logic                  dz_w    [0:DATA_WIDTH];

    assign valid_w[0] = in_valid;
    assign in_ready   = ready_w[0];
    assign rem_w[0]   = '0;
    assign nq_w[0]    = dividend;
    assign div_w[0]   = divisor;
    assign dz_w[0]    = (divisor == '0);

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_stage
        rud_stage #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_w[i]),
            .up_ready (ready_w[i]),
            .up_rem   (rem_w[i]),
            .up_nq    (nq_w[i]),
            .up_div   (div_w[i]),
            .up_dz    (dz_w[i]),
            .dn_valid (valid_w[i+1]),
            .dn_ready (ready_w[i+1]),
            .dn_rem   (rem_w[i+1]),
            .dn_nq    (nq_w[i+1]),
            .dn_div   (div_w[i+1]),
            .dn_dz    (dz_w[i+1])
        );
    end

    assign ready_w[DATA_WIDTH] = out_ready;
    assign out_valid           = valid_w[DATA_WIDTH];
    assign divide_by_zero      = dz_w[DATA_WIDTH];
    assign quotient            = dz_w[DATA_WIDTH] ? '0 : nq_w[DATA_WIDTH];
    assign remainder           = dz_w[DATA_WIDTH] ? '0 : rem_w[DATA_WIDTH];

`ifndef SYNTHESIS
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> quotient == '0 && remainder == '0)
        else $error("divide by zero word carries a nonzero result");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !divide_by_zero |-> remainder < div_w[DATA_WIDTH])
        else $error("remainder is not below the divisor");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_w[1])
        else $error("accepted word did not reach the first stage");
`endif

endmodule

// ===== rtl/core/rud_stage.sv =====
// One restoring division step as a registered pipeline stage.
// Resolves one quotient bit per word and holds it until the next stage can take it.
// Depends on rud_pkg for the default width.
module rud_stage #(
    parameter int DATA_WIDTH = rud_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [DATA_WIDTH-1:0] up_rem,
    input  logic [DATA_WIDTH-1:0] up_nq,
    input  logic [DATA_WIDTH-1:0] up_div,
    input  logic                  up_dz,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [DATA_WIDTH-1:0] dn_rem,
    output logic [DATA_WIDTH-1:0] dn_nq,
    output logic [DATA_WIDTH-1:0] dn_div,
    output logic                  dn_dz
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] nq_reg;
    logic [DATA_WIDTH-1:0] div_reg;
    logic                  dz_reg;

    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH+1:0] diff;
    logic                  take;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] nq_next;

    // The bit shifted out of the partial remainder acts as an extra top bit,
    // so the compare is one bit wider than the operands, with a further top bit for the borrow.
    always_comb
    begin
        shifted  = {up_rem[DATA_WIDTH-2:0], up_nq[DATA_WIDTH-1]};
        diff     = {1'b0, up_rem[DATA_WIDTH-1], shifted} - {2'b00, up_div};
        take     = ~diff[DATA_WIDTH+1];
        rem_next = take ? diff[DATA_WIDTH-1:0] : shifted;
        nq_next  = {up_nq[DATA_WIDTH-2:0], take};
    end

    assign up_ready = ~valid_reg | dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            div_reg <= up_div;
            dz_reg  <= up_dz;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_nq    = nq_reg;
    assign dn_div   = div_reg;
    assign dn_dz    = dz_reg;

endmodule
